// File: design/tfn_pkg.sv
package tfn_pkg;

  // Coordinate and result widths
  localparam int unsigned CoordW  = 24;
  localparam int unsigned EdgeW   = 25;
  localparam int unsigned ProdW   = 50;
  localparam int unsigned CrossW  = 51;
  localparam int unsigned MagW    = 50;
  localparam int unsigned LenW    = 6;
  localparam int unsigned TopW    = 24;
  localparam int unsigned SqW     = 48;
  localparam int unsigned RadW    = 50;
  localparam int unsigned ResW    = 51;
  localparam int unsigned RootW   = 25;
  localparam int unsigned DenW    = 26;
  localparam int unsigned RemW    = 41;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned NormW   = 16;

  // Pipeline layout
  localparam int unsigned FrontStages = 8;
  localparam int unsigned SqrtSteps   = 25;
  localparam int unsigned DivSteps    = 15;
  localparam int unsigned SqrtFirst   = FrontStages;
  localparam int unsigned DivFirst    = FrontStages + SqrtSteps;
  localparam int unsigned OutStage    = DivFirst + DivSteps;
  localparam int unsigned NumStages   = OutStage + 1;

  typedef struct packed {
    logic [IdxW-1:0]          first_vertex_index;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic [IdxW-1:0]         vertex_index_out;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } normal_out_t;

  // Sideband carried alongside the root and divide steps
  typedef struct packed {
    logic [IdxW-1:0]            idx;
    logic [2:0]                 neg;
    logic                       zero;
    logic [2:0][TopW-1:0]       q;
  } side_t;

endpackage

// File: design/triangle_face_normal.sv
// Unit face normal of one triangle, fully pipelined over 49 register stages.
// Throughput one triangle per clock while the output is not stalled, as the 25-step
// square root and the 15-step divide take one step a stage.
// Each stage holds its item while the stage after it is full and stalled.
// Reset clears all stage valid bits; data registers are not reset.
module triangle_face_normal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tfn_pkg::tri_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tfn_pkg::normal_out_t out_data_o
);

  localparam int unsigned NS = tfn_pkg::NumStages;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // Ready ripples back: a stage loads when empty or when it drains
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  // Stage 0: edge vectors
  logic [tfn_pkg::IdxW-1:0]          idx0_q;
  logic signed [tfn_pkg::EdgeW-1:0]  e0_q [3];
  logic signed [tfn_pkg::EdgeW-1:0]  e1_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      idx0_q  <= in_data_i.first_vertex_index;
      e0_q[0] <= tfn_pkg::EdgeW'(in_data_i.ax) - tfn_pkg::EdgeW'(in_data_i.bx);
      e0_q[1] <= tfn_pkg::EdgeW'(in_data_i.ay) - tfn_pkg::EdgeW'(in_data_i.by_coord);
      e0_q[2] <= tfn_pkg::EdgeW'(in_data_i.az) - tfn_pkg::EdgeW'(in_data_i.bz);
      e1_q[0] <= tfn_pkg::EdgeW'(in_data_i.ax) - tfn_pkg::EdgeW'(in_data_i.cx);
      e1_q[1] <= tfn_pkg::EdgeW'(in_data_i.ay) - tfn_pkg::EdgeW'(in_data_i.cy);
      e1_q[2] <= tfn_pkg::EdgeW'(in_data_i.az) - tfn_pkg::EdgeW'(in_data_i.cz);
    end
  end

  // Stage 1: six partial products of the cross product
  logic [tfn_pkg::IdxW-1:0]          idx1_q;
  logic signed [tfn_pkg::ProdW-1:0]  pr_q [6];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      idx1_q   <= idx0_q;
      pr_q[0]  <= tfn_pkg::ProdW'(e0_q[1]) * tfn_pkg::ProdW'(e1_q[2]);
      pr_q[1]  <= tfn_pkg::ProdW'(e0_q[2]) * tfn_pkg::ProdW'(e1_q[1]);
      pr_q[2]  <= tfn_pkg::ProdW'(e0_q[2]) * tfn_pkg::ProdW'(e1_q[0]);
      pr_q[3]  <= tfn_pkg::ProdW'(e0_q[0]) * tfn_pkg::ProdW'(e1_q[2]);
      pr_q[4]  <= tfn_pkg::ProdW'(e0_q[0]) * tfn_pkg::ProdW'(e1_q[1]);
      pr_q[5]  <= tfn_pkg::ProdW'(e0_q[1]) * tfn_pkg::ProdW'(e1_q[0]);
    end
  end

  // Stage 2: cross product
  logic [tfn_pkg::IdxW-1:0]          idx2_q;
  logic signed [tfn_pkg::CrossW-1:0] p_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      idx2_q <= idx1_q;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= tfn_pkg::CrossW'(pr_q[2*i]) - tfn_pkg::CrossW'(pr_q[2*i+1]);
      end
    end
  end

  // Stage 3: magnitudes and signs
  logic [tfn_pkg::IdxW-1:0]  idx3_q;
  logic [tfn_pkg::MagW-1:0]  mag3_q [3];
  logic [2:0]                neg3_q;
  logic [tfn_pkg::CrossW-1:0] abs_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = p_q[i][tfn_pkg::CrossW-1] ? tfn_pkg::CrossW'(-p_q[i])
                                            : tfn_pkg::CrossW'(p_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      idx3_q <= idx2_q;
      for (int i = 0; i < 3; i++) begin
        mag3_q[i] <= abs_v[i][tfn_pkg::MagW-1:0];
        neg3_q[i] <= p_q[i][tfn_pkg::CrossW-1];
      end
    end
  end

  // Stage 4: bit length of the largest magnitude, taken from the OR of all
  logic [tfn_pkg::IdxW-1:0]  idx4_q;
  logic [tfn_pkg::MagW-1:0]  mag4_q [3];
  logic [2:0]                neg4_q;
  logic [tfn_pkg::LenW-1:0]  len4_q;
  logic [tfn_pkg::MagW-1:0]  or_v;
  logic [tfn_pkg::LenW-1:0]  len_d;

  always_comb begin
    or_v  = mag3_q[0] | mag3_q[1] | mag3_q[2];
    len_d = '0;
    for (int i = 0; i < tfn_pkg::MagW; i++) begin
      if (or_v[i]) begin
        len_d = tfn_pkg::LenW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      idx4_q <= idx3_q;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      len4_q <= len_d;
    end
  end

  // Stage 5: bring the largest magnitude into [2^23, 2^24)
  tfn_pkg::side_t           side5_q;
  logic [tfn_pkg::MagW-1:0] shv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len4_q < tfn_pkg::LenW'(tfn_pkg::TopW)) begin
        shv[i] = mag4_q[i] << (tfn_pkg::LenW'(tfn_pkg::TopW) - len4_q);
      end else begin
        shv[i] = mag4_q[i] >> (len4_q - tfn_pkg::LenW'(tfn_pkg::TopW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      side5_q.idx  <= idx4_q;
      side5_q.neg  <= neg4_q;
      side5_q.zero <= (len4_q == '0);
      for (int i = 0; i < 3; i++) begin
        side5_q.q[i] <= shv[i][tfn_pkg::TopW-1:0];
      end
    end
  end

  // Stage 6: squares
  tfn_pkg::side_t          side6_q;
  logic [tfn_pkg::SqW-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      side6_q <= side5_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= tfn_pkg::SqW'(side5_q.q[i]) * tfn_pkg::SqW'(side5_q.q[i]);
      end
    end
  end

  // Stage 7: sum of squares
  tfn_pkg::side_t           side7_q;
  logic [tfn_pkg::RadW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      side7_q <= side6_q;
      rad_q   <= tfn_pkg::RadW'(sq_q[0]) + tfn_pkg::RadW'(sq_q[1])
               + tfn_pkg::RadW'(sq_q[2]);
    end
  end

  // Square root steps, sideband travels alongside
  logic [tfn_pkg::RootW-1:0] root;
  tfn_pkg::side_t            sside_q [tfn_pkg::SqrtSteps];

  tfn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (rdy[tfn_pkg::SqrtFirst +: tfn_pkg::SqrtSteps]),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[tfn_pkg::SqrtFirst]) begin
      sside_q[0] <= side7_q;
    end
    for (int k = 1; k < tfn_pkg::SqrtSteps; k++) begin
      if (rdy[tfn_pkg::SqrtFirst + k]) begin
        sside_q[k] <= sside_q[k-1];
      end
    end
  end

  // Divide steps: three restoring lanes, one quotient bit per stage
  logic [tfn_pkg::RemW-1:0]  rem_q  [tfn_pkg::DivSteps][3];
  logic [tfn_pkg::QuotW-1:0] quot_q [tfn_pkg::DivSteps][3];
  logic [tfn_pkg::DenW-1:0]  den_q  [tfn_pkg::DivSteps];
  logic [tfn_pkg::IdxW-1:0]  didx_q [tfn_pkg::DivSteps];
  logic [2:0]                dneg_q [tfn_pkg::DivSteps];
  logic                      dzero_q [tfn_pkg::DivSteps];

  for (genvar j = 0; j < tfn_pkg::DivSteps; j++) begin : g_div
    localparam int unsigned BitPos = tfn_pkg::DivSteps - 1 - j;
    logic [tfn_pkg::DenW-1:0]  den_in;
    logic [tfn_pkg::RemW-1:0]  trial;
    logic [tfn_pkg::RemW-1:0]  rem_in [3];
    logic [tfn_pkg::QuotW-1:0] quot_in [3];
    logic [tfn_pkg::RemW-1:0]  rem_d [3];
    logic [tfn_pkg::QuotW-1:0] quot_d [3];

    always_comb begin
      if (j == 0) begin
        den_in = {root, 1'b0};
        for (int i = 0; i < 3; i++) begin
          rem_in[i]  = (tfn_pkg::RemW'(sside_q[tfn_pkg::SqrtSteps-1].q[i])
                        << tfn_pkg::QuotW) + tfn_pkg::RemW'(root);
          quot_in[i] = '0;
        end
      end else begin
        den_in = den_q[(j > 0) ? j - 1 : 0];
        for (int i = 0; i < 3; i++) begin
          rem_in[i]  = rem_q[(j > 0) ? j - 1 : 0][i];
          quot_in[i] = quot_q[(j > 0) ? j - 1 : 0][i];
        end
      end
      trial = tfn_pkg::RemW'(den_in) << BitPos;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= trial) begin
          rem_d[i]  = rem_in[i] - trial;
          quot_d[i] = quot_in[i] | (tfn_pkg::QuotW'(1) << BitPos);
        end else begin
          rem_d[i]  = rem_in[i];
          quot_d[i] = quot_in[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[tfn_pkg::DivFirst + j]) begin
        den_q[j] <= den_in;
        for (int i = 0; i < 3; i++) begin
          rem_q[j][i]  <= rem_d[i];
          quot_q[j][i] <= quot_d[i];
        end
        if (j == 0) begin
          didx_q[j]  <= sside_q[tfn_pkg::SqrtSteps-1].idx;
          dneg_q[j]  <= sside_q[tfn_pkg::SqrtSteps-1].neg;
          dzero_q[j] <= sside_q[tfn_pkg::SqrtSteps-1].zero;
        end else begin
          didx_q[j]  <= didx_q[(j > 0) ? j - 1 : 0];
          dneg_q[j]  <= dneg_q[(j > 0) ? j - 1 : 0];
          dzero_q[j] <= dzero_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  // Output stage: apply signs, zero a degenerate triangle
  localparam int unsigned LastDiv = tfn_pkg::DivSteps - 1;

  tfn_pkg::normal_out_t     out_q;
  logic [tfn_pkg::NormW-1:0] comp_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dzero_q[LastDiv]) begin
        comp_v[i] = '0;
      end else if (dneg_q[LastDiv][i]) begin
        comp_v[i] = tfn_pkg::NormW'(-{1'b0, quot_q[LastDiv][i]});
      end else begin
        comp_v[i] = {1'b0, quot_q[LastDiv][i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[tfn_pkg::OutStage]) begin
      out_q.vertex_index_out <= didx_q[LastDiv];
      out_q.normal_x         <= comp_v[0];
      out_q.normal_y         <= comp_v[1];
      out_q.normal_z         <= comp_v[2];
      out_q.degenerate       <= dzero_q[LastDiv];
    end
  end

  assign out_data_o = out_q;

endmodule

// File: design/tfn_isqrt.sv
module tfn_isqrt (
  input  logic                                clk_i,
  input  logic [tfn_pkg::SqrtSteps-1:0]       en_i,
  input  logic [tfn_pkg::RadW-1:0]            rad_i,
  output logic [tfn_pkg::RootW-1:0]           root_o
);

  logic [tfn_pkg::RadW-1:0] rem_q [tfn_pkg::SqrtSteps];
  logic [tfn_pkg::ResW-1:0] res_q [tfn_pkg::SqrtSteps];

  // One result bit per stage, digit recurrence from the top even power
  for (genvar k = 0; k < tfn_pkg::SqrtSteps; k++) begin : g_step
    localparam int unsigned BitPos = 2 * (tfn_pkg::SqrtSteps - 1 - k);
    logic [tfn_pkg::RadW-1:0] rem_in;
    logic [tfn_pkg::ResW-1:0] res_in;
    logic [tfn_pkg::ResW-1:0] trial;
    logic [tfn_pkg::ResW-1:0] bit_v;
    logic [tfn_pkg::RadW-1:0] rem_d;
    logic [tfn_pkg::ResW-1:0] res_d;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign bit_v = tfn_pkg::ResW'(1) << BitPos;
    assign trial = res_in + bit_v;

    always_comb begin
      if (tfn_pkg::ResW'(rem_in) >= trial) begin
        rem_d = rem_in - tfn_pkg::RadW'(trial);
        res_d = (res_in >> 1) + bit_v;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[tfn_pkg::SqrtSteps-1][tfn_pkg::RootW-1:0];

endmodule
